>>> sv/usfl_pkg.sv
// usfl_pkg: codes, frame constants and the packet and job types for the sensor frame link
// no dependencies; imported by every module of the block
package usfl_pkg;

  localparam int FRAME_BYTES_DEF = 32;
  localparam int READINGS = 6;

  localparam logic [1:0] FUNC_RX    = 2'd0;
  localparam logic [1:0] FUNC_SHELL = 2'd1;
  localparam logic [1:0] FUNC_BT    = 2'd2;

  localparam logic [1:0] REQ_NONE = 2'd0;

  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_PACKET = 2'd1;
  localparam logic [1:0] KIND_BUSY   = 2'd2;

  localparam logic [7:0] BYTE_SOF      = 8'hAA;
  localparam logic [7:0] BYTE_TYPE_LEN = 8'h12;
  localparam logic [7:0] BYTE_EOF      = 8'hFA;
  localparam logic [7:0] BYTE_NULL     = 8'h00;
  localparam logic [3:0] MULTI_LEN_MAX = 4'd9;

  localparam logic [2:0] TX_IDX_SOF    = 3'd0;
  localparam logic [2:0] TX_IDX_TYPE   = 3'd1;
  localparam logic [2:0] TX_IDX_DEVICE = 3'd2;
  localparam logic [2:0] TX_IDX_OPTION = 3'd3;
  localparam logic [2:0] TX_IDX_EOF    = 3'd4;

  typedef struct packed {
    logic [7:0]                  device;
    logic [READINGS-1:0][31:0]   reading;
    logic [1:0]                  dest;
    logic                        multi;
  } packet_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tx_device;
    logic [7:0] tx_option;
    packet_t    packet;
  } job_t;

endpackage

>>> sv/usfl_frame_rx.sv
// usfl_frame_rx: receive frame store, write position and parallel packet decode
// depends on usfl_pkg
module usfl_frame_rx #(
  parameter int FRAME_BYTES = usfl_pkg::FRAME_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  output logic             close_hit,
  output usfl_pkg::packet_t packet
);
  import usfl_pkg::*;

  localparam int WPW = $clog2(FRAME_BYTES);
  localparam logic [WPW-1:0] WP_MAX = WPW'(FRAME_BYTES - 1);
  localparam int DEC_BYTES = 3 + 4 * READINGS;

  logic [7:0]     store [FRAME_BYTES];
  logic [WPW-1:0] wp;
  logic [7:0]     dec_b [DEC_BYTES];
  logic           skip;

  assign skip      = (wp == '0) && (rx_byte == BYTE_NULL);
  assign close_hit = (rx_byte == BYTE_EOF) && (wp != '0);

  // bytes as they stand once the closing zero is in place
  for (genvar i = 0; i < DEC_BYTES; i++) begin : g_dec
    assign dec_b[i] = (wp == WPW'(i)) ? BYTE_NULL : store[i];
  end

  always_comb begin
    packet.device = dec_b[2];
    packet.multi  = (dec_b[1][3:0] > MULTI_LEN_MAX);
    packet.dest   = REQ_NONE;
    for (int k = 0; k < READINGS; k++) begin
      packet.reading[k] = {dec_b[6+4*k], dec_b[5+4*k], dec_b[4+4*k], dec_b[3+4*k]};
      if (k >= 2 && !packet.multi) begin
        packet.reading[k] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      for (int i = 0; i < FRAME_BYTES; i++) begin
        store[i] <= '0;
      end
    end else if (step && !skip) begin
      if (close_hit) begin
        store[wp] <= BYTE_NULL;
        wp        <= '0;
      end else if (wp < WP_MAX) begin
        store[wp] <= rx_byte;
        wp        <= wp + 1'b1;
      end
    end
  end

endmodule

>>> sv/usfl_emitter.sv
// usfl_emitter: result register and sequencer that plays one job out as one to five items
// depends on usfl_pkg
module usfl_emitter (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  usfl_pkg::job_t    job_in,
  output logic              can_take,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        kind,
  output logic [7:0]        tx_byte,
  output logic              last,
  output usfl_pkg::packet_t packet
);
  import usfl_pkg::*;

  job_t       job;
  logic       busy;
  logic [2:0] idx;
  logic       fire;

  assign out_valid = busy;
  assign kind      = job.kind;
  assign packet    = job.packet;
  assign last      = (job.kind != KIND_TX) || (idx == TX_IDX_EOF);
  assign fire      = busy && !out_stall;
  assign can_take  = !busy || (fire && last);

  always_comb begin
    tx_byte = '0;
    if (job.kind == KIND_TX) begin
      unique case (idx)
        TX_IDX_SOF:    tx_byte = BYTE_SOF;
        TX_IDX_TYPE:   tx_byte = BYTE_TYPE_LEN;
        TX_IDX_DEVICE: tx_byte = job.tx_device;
        TX_IDX_OPTION: tx_byte = job.tx_option;
        TX_IDX_EOF:    tx_byte = BYTE_EOF;
        default:       tx_byte = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= TX_IDX_SOF;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= TX_IDX_SOF;
    end else if (fire) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job <= job_in;
    end
  end

endmodule

>>> sv/uart_sensor_frame_link.sv
// uart_sensor_frame_link: request framing and receive frame decode for a sensor link
// a taken item passes through the input register, then the result register, before its result leaves
// throughput: one item per cycle while in_stall is low; a request holds the result register until its five
// transmit bytes are taken, one per transmit byte, other results until their single item is taken
// reset clears the input register's valid flag, the frame store, the write position and the pending requester
// depends on usfl_pkg, usfl_frame_rx, usfl_emitter
module uart_sensor_frame_link #(
  parameter int FRAME_BYTES = usfl_pkg::FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [7:0]  rx_byte,
  input  logic [7:0]  request_device,
  input  logic [7:0]  request_option,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  tx_byte,
  output logic        last,
  output logic [7:0]  packet_device,
  output logic [31:0] reading_one,
  output logic [31:0] reading_two,
  output logic [31:0] reading_three,
  output logic [31:0] reading_four,
  output logic [31:0] reading_five,
  output logic [31:0] reading_six,
  output logic [1:0]  destination,
  output logic        multi_reading
);
  import usfl_pkg::*;

  logic       item_valid;
  logic [1:0] item_func;
  logic [7:0] item_byte;
  logic [7:0] item_device;
  logic [7:0] item_option;
  logic [1:0] pending;
  logic [1:0] pending_next;

  logic       is_req;
  logic       is_rx;
  logic       close_hit;
  logic       needs_result;
  logic       can_take;
  logic       advance;
  logic       load;
  packet_t    rx_packet;
  packet_t    out_packet;
  job_t       job;

  assign is_req = (item_func == FUNC_SHELL) || (item_func == FUNC_BT);
  assign is_rx  = (item_func == FUNC_RX);

  assign needs_result = is_req || (is_rx && close_hit && pending != REQ_NONE);
  assign advance      = item_valid && (!needs_result || can_take);
  assign load         = advance && needs_result;
  assign in_stall     = item_valid && !advance;

  always_comb begin
    job           = '0;
    pending_next  = pending;
    if (is_req) begin
      job.tx_device = item_device;
      job.tx_option = item_option;
      if (pending != REQ_NONE) begin
        job.kind = KIND_BUSY;
      end else begin
        job.kind     = KIND_TX;
        pending_next = item_func;
      end
    end else if (is_rx && close_hit) begin
      job.kind        = KIND_PACKET;
      job.packet      = rx_packet;
      job.packet.dest = pending;
      pending_next    = REQ_NONE;
    end
    if (job.kind != KIND_TX) begin
      job.tx_device = '0;
      job.tx_option = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      pending    <= REQ_NONE;
    end else begin
      if (in_valid && !in_stall) begin
        item_valid <= 1'b1;
      end else if (advance) begin
        item_valid <= 1'b0;
      end
      if (advance) begin
        pending <= pending_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_func   <= func;
      item_byte   <= rx_byte;
      item_device <= request_device;
      item_option <= request_option;
    end
  end

  usfl_frame_rx #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_frame_rx (
    .clk       (clk),
    .rst       (rst),
    .step      (advance && is_rx),
    .rx_byte   (item_byte),
    .close_hit (close_hit),
    .packet    (rx_packet)
  );

  usfl_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .job_in    (job),
    .can_take  (can_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .tx_byte   (tx_byte),
    .last      (last),
    .packet    (out_packet)
  );

  assign packet_device = out_packet.device;
  assign reading_one   = out_packet.reading[0];
  assign reading_two   = out_packet.reading[1];
  assign reading_three = out_packet.reading[2];
  assign reading_four  = out_packet.reading[3];
  assign reading_five  = out_packet.reading[4];
  assign reading_six   = out_packet.reading[5];
  assign destination   = out_packet.dest;
  assign multi_reading = out_packet.multi;

endmodule

>>> tb/uart_sensor_frame_link_test.sv
`timescale 1ns / 1ps
// uart_sensor_frame_link_test: self-checking bench for the sensor frame link, with a directed
// table then random request/frame traffic under bursty sending and patterned stalls
// depends on usfl_pkg and uart_sensor_frame_link
module uart_sensor_frame_link_test;
  import usfl_pkg::*;

  localparam int FRAME_BYTES = FRAME_BYTES_DEF;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 410;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 10;

  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_BUSY, CHK_REQUEST} check_t;
  typedef enum int {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_PERIODIC} stall_t;

  typedef struct packed {
    logic [1:0] fn;
    logic [7:0] rx;
    logic [7:0] dev;
    logic [7:0] opt;
    check_t     chk;
  } stim_t;

  typedef struct packed {
    logic [1:0]                kind;
    logic [7:0]                tx;
    logic                      last;
    logic [7:0]                device;
    logic [READINGS-1:0][31:0] reading;
    logic [1:0]                dest;
    logic                      multi;
  } result_t;

  // expected outcome typed in where it is plain, otherwise taken from the predictor
  localparam stim_t DIRECTED_ROWS [25] = '{
    '{FUNC_UNUSED, 8'hFF, 8'hFF, 8'hFF, CHK_NONE},
    '{FUNC_RX,     8'h00, 8'h00, 8'h00, CHK_NONE},
    '{FUNC_RX,     8'hFA, 8'h00, 8'h00, CHK_NONE},
    '{FUNC_RX,     8'hFA, 8'h00, 8'h00, CHK_NONE},
    '{FUNC_SHELL,  8'h00, 8'h00, 8'h00, CHK_REQUEST},
    '{FUNC_BT,     8'h00, 8'hFF, 8'hFF, CHK_BUSY},
    '{FUNC_SHELL,  8'h00, 8'h5A, 8'hA5, CHK_BUSY},
    '{FUNC_RX,     8'h00, 8'h00, 8'h00, CHK_NONE},
    '{FUNC_RX,     8'h55, 8'h00, 8'h00, CHK_MODEL},
    '{FUNC_RX,     8'h1F, 8'h00, 8'h00, CHK_MODEL},
    '{FUNC_RX,     8'h80, 8'h00, 8'h00, CHK_MODEL},
    '{FUNC_RX,     8'h01, 8'h00, 8'h00, CHK_MODEL},
    '{FUNC_RX,     8'h02, 8'h00, 8'h00, CHK_MODEL},
    '{FUNC_RX,     8'h03, 8'h00, 8'h00, CHK_MODEL},
    '{FUNC_RX,     8'h04, 8'h00, 8'h00, CHK_MODEL},
    '{FUNC_RX,     8'hFA, 8'h00, 8'h00, CHK_MODEL},
    '{FUNC_BT,     8'h00, 8'hFF, 8'hFF, CHK_REQUEST},
    '{FUNC_RX,     8'h00, 8'h00, 8'h00, CHK_NONE},
    '{FUNC_RX,     8'h11, 8'h00, 8'h00, CHK_MODEL},
    '{FUNC_RX,     8'h09, 8'h00, 8'h00, CHK_MODEL},
    '{FUNC_RX,     8'hFF, 8'h00, 8'h00, CHK_MODEL},
    '{FUNC_RX,     8'hFF, 8'h00, 8'h00, CHK_MODEL},
    '{FUNC_RX,     8'h00, 8'h00, 8'h00, CHK_MODEL},
    '{FUNC_RX,     8'hFE, 8'h00, 8'h00, CHK_MODEL},
    '{FUNC_RX,     8'hFA, 8'h00, 8'h00, CHK_MODEL}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  func = FUNC_RX;
  logic [7:0]  rx_byte = '0;
  logic [7:0]  request_device = '0;
  logic [7:0]  request_option = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  tx_byte;
  logic        last;
  logic [7:0]  packet_device;
  logic [31:0] reading_one;
  logic [31:0] reading_two;
  logic [31:0] reading_three;
  logic [31:0] reading_four;
  logic [31:0] reading_five;
  logic [31:0] reading_six;
  logic [1:0]  destination;
  logic        multi_reading;

  uart_sensor_frame_link dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [7:0] frame_mem [FRAME_BYTES];
  int         frame_pos = 0;
  logic [1:0] owner = REQ_NONE;
  result_t    link_out_q [$];

  int     mismatches = 0;
  int     live_items = 0;
  int     burst_left = 0;
  int     cycle_count = 0;
  logic   in_go = 1'b0;
  stall_t stall_mode = STALL_NONE;
  int     stall_left = 0;
  int     stall_tick = 0;

  function automatic result_t tx_result(input logic [7:0] b, input logic fin);
    result_t r;
    r = '0;
    r.kind = KIND_TX;
    r.tx = b;
    r.last = fin;
    return r;
  endfunction

  function automatic logic [31:0] word_at(input int at);
    logic [31:0] w;
    w = '0;
    for (int k = 0; k < 4; k++)
      if (at + k < FRAME_BYTES) w[8*k +: 8] = frame_mem[at + k];
    return w;
  endfunction

  task automatic push_refusal();
    result_t r;
    r = '0;
    r.kind = KIND_BUSY;
    r.last = 1'b1;
    link_out_q.push_back(r);
  endtask

  task automatic push_request_bytes(input logic [7:0] dev, input logic [7:0] opt);
    link_out_q.push_back(tx_result(BYTE_SOF, 1'b0));
    link_out_q.push_back(tx_result(BYTE_TYPE_LEN, 1'b0));
    link_out_q.push_back(tx_result(dev, 1'b0));
    link_out_q.push_back(tx_result(opt, 1'b0));
    link_out_q.push_back(tx_result(BYTE_EOF, 1'b1));
  endtask

  task automatic predict_link(input stim_t s);
    result_t r;
    logic    multi;
    if (s.fn == FUNC_SHELL || s.fn == FUNC_BT) begin
      if (owner != REQ_NONE) begin
        push_refusal();
      end else begin
        owner = s.fn;
        push_request_bytes(s.dev, s.opt);
      end
    end else if (s.fn == FUNC_RX) begin
      if (frame_pos == 0 && s.rx == BYTE_NULL) begin
        // leading zero dropped
      end else if (s.rx == BYTE_EOF && frame_pos != 0) begin
        if (frame_pos < FRAME_BYTES) frame_mem[frame_pos] = BYTE_NULL;
        multi = frame_mem[1][3:0] > MULTI_LEN_MAX;
        if (owner != REQ_NONE) begin
          r = '0;
          r.kind = KIND_PACKET;
          r.last = 1'b1;
          r.device = frame_mem[2];
          for (int i = 0; i < READINGS; i++)
            r.reading[i] = (i < 2 || multi) ? word_at(3 + 4 * i) : 32'd0;
          r.dest = owner;
          r.multi = multi;
          link_out_q.push_back(r);
        end
        owner = REQ_NONE;
        frame_pos = 0;
      end else if (frame_pos < FRAME_BYTES - 1) begin
        frame_mem[frame_pos] = s.rx;
        frame_pos++;
      end
    end
  endtask

  task automatic send_item(input stim_t s);
    int gap;
    int n0;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
    in_valid <= 1'b1;
    func <= s.fn;
    rx_byte <= s.rx;
    request_device <= s.dev;
    request_option <= s.opt;
    @(posedge clk);
    while (!in_go) @(posedge clk);
    if (!(s.fn == FUNC_UNUSED || (s.fn == FUNC_RX && s.rx == BYTE_NULL && frame_pos == 0)))
      live_items++;
    n0 = link_out_q.size();
    predict_link(s);
    if (s.chk != CHK_MODEL) begin
      while (link_out_q.size() > n0) void'(link_out_q.pop_back());
      if (s.chk == CHK_BUSY) push_refusal();
      else if (s.chk == CHK_REQUEST) push_request_bytes(s.dev, s.opt);
    end
    burst_left--;
  endtask

  function automatic stim_t make_stim(input logic [1:0] fn, input logic [7:0] rx);
    stim_t s;
    s.fn = fn;
    s.rx = rx;
    s.dev = 8'($urandom_range(0, 255));
    s.opt = 8'($urandom_range(0, 255));
    s.chk = CHK_MODEL;
    return s;
  endfunction

  function automatic int frame_len();
    return ($urandom_range(0, 4) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 27);
  endfunction

  task automatic send_frame(input int len);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      if (b == BYTE_EOF && i > 0) b = ~b;
      send_item(make_stim(FUNC_RX, b));
      if ($urandom_range(0, 19) == 0)
        send_item(make_stim(2'($urandom_range(FUNC_SHELL, FUNC_BT)), 8'h00));
    end
    send_item(make_stim(FUNC_RX, BYTE_EOF));
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    @(posedge clk);
    while (link_out_q.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %h got %h", $time, name, want, got);
    end
  endtask

  // handshakes are judged on the falling edge ahead of the rising edge that takes them
  always @(negedge clk) begin : watch_results
    result_t due;
    result_t got;
    in_go = !rst && in_valid && !in_stall;
    if (!rst && out_valid && !out_stall) begin
      if (link_out_q.size() == 0) begin
        mismatches++;
        $display("%0t: result expected none got kind %0d", $time, kind);
      end else begin
        due = link_out_q.pop_front();
        got.kind = kind;
        got.tx = tx_byte;
        got.last = last;
        got.device = packet_device;
        got.reading = {reading_six, reading_five, reading_four,
                       reading_three, reading_two, reading_one};
        got.dest = destination;
        got.multi = multi_reading;
        check_field("kind", 32'(due.kind), 32'(got.kind));
        check_field("tx_byte", 32'(due.tx), 32'(got.tx));
        check_field("last", 32'(due.last), 32'(got.last));
        check_field("packet_device", 32'(due.device), 32'(got.device));
        for (int i = 0; i < READINGS; i++)
          check_field($sformatf("reading %0d", i + 1), due.reading[i], got.reading[i]);
        check_field("destination", 32'(due.dest), 32'(got.dest));
        check_field("multi_reading", 32'(due.multi), 32'(got.multi));
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_t'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 120);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      STALL_NONE: out_stall <= 1'b0;
      STALL_HALF: out_stall <= 1'($urandom_range(0, 1));
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_tick % 7) < 3;
    endcase
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int pick;
    for (int i = 0; i < FRAME_BYTES; i++) frame_mem[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < $size(DIRECTED_ROWS); i++) send_item(DIRECTED_ROWS[i]);

    // hold off until the directed results are all back
    wait_results_done();
    live_items = 0;
    while (live_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_item(make_stim(2'($urandom_range(FUNC_SHELL, FUNC_BT)), 8'h00));
        repeat ($urandom_range(0, 2)) send_item(make_stim(FUNC_RX, BYTE_NULL));
        send_frame(frame_len());
      end else if (pick < 72) begin
        send_frame(frame_len());
      end else if (pick < 82) begin
        send_item(make_stim(2'($urandom_range(FUNC_SHELL, FUNC_BT)), 8'h00));
        send_item(make_stim(2'($urandom_range(FUNC_SHELL, FUNC_BT)), 8'h00));
        send_frame($urandom_range(1, 14));
      end else if (pick < 94) begin
        repeat ($urandom_range(1, 6))
          send_item(make_stim(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255))));
      end else begin
        wait_results_done();
      end
    end

    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && link_out_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
